// ===== rtl/vwc_pkg.sv =====
// Package for the voxel web classifier: payload structs, codes, constants.
// Used by the front, queue, back, top and bench modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vwc_pkg;

    localparam int GRID_SIDE_MAX_DEF = 64;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam int CELL_W            = 24;  // widest store address (side 256)
    localparam int OUT_CELL_W        = 18;
    localparam int CFG_IDX_W         = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALO_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd3;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] WEB_VOID     = 2'd0;
    localparam logic [1:0] WEB_SHEET    = 2'd1;
    localparam logic [1:0] WEB_FILAMENT = 2'd2;
    localparam logic [1:0] WEB_KNOT     = 2'd3;

    localparam logic [6:0]  GRID_SIDE_RST = 7'd64;
    localparam logic [31:0] SCALE_RST     = 32'h0001_0000;
    localparam logic [31:0] THRESHOLD_RST = 32'h0000_0000;

    typedef struct packed {
        logic               func;
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic [31:0]        pos_z;
        logic signed [31:0] eigen_first;
        logic signed [31:0] eigen_second;
        logic signed [31:0] eigen_third;
        logic [63:0]        halo_tag;
    } t_in;

    typedef struct packed {
        logic [63:0]           halo_tag_out;
        logic [1:0]            web_type;
        logic [OUT_CELL_W-1:0] cell_index;
        logic                  out_of_range;
        logic [31:0]           knot_total;
        logic [31:0]           filament_total;
        logic [31:0]           sheet_total;
        logic [31:0]           void_total;
    } t_out;

    typedef struct packed {
        logic [6:0]         grid_side;
        logic [31:0]        index_scale;
        logic [31:0]        halo_unit_scale;
        logic signed [31:0] eigen_threshold;
    } t_cfg;

    // one classified item travelling from front to back
    typedef struct packed {
        logic               func;
        logic signed [31:0] eigen_first;
        logic signed [31:0] eigen_second;
        logic signed [31:0] eigen_third;
        logic [63:0]        halo_tag;
        logic               oor;
        logic [CELL_W-1:0]  vox;
    } t_job;

endpackage

`default_nettype wire

// ===== rtl/vwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module vwc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 262144
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vwc_queue.sv =====
// Small register FIFO of classified items between front and back.
// Depends on vwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire vwc_pkg::t_job i_push_job,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output vwc_pkg::t_job      o_pop_job
);
    import vwc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vwc_front.sv =====
// Front end: accepts items and turns positions into a voxel index.
// One shared 32x32 multiplier is stepped through the axes. Depends on vwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwc_front #(
    parameter int GRID_SIDE_MAX = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire vwc_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire vwc_pkg::t_in  i_item,
    output logic               o_job_valid,
    input  wire logic          i_job_ready,
    output vwc_pkg::t_job      o_job
);
    import vwc_pkg::*;

    localparam int IW = $clog2(GRID_SIDE_MAX);
    localparam int SW = $clog2(GRID_SIDE_MAX + 1);

    typedef enum logic [3:0] {
        F_IDLE, F_HUS, F_SAT, F_IDX, F_CMP, F_SQ, F_KSQ, F_JS, F_SUM
    } t_fstate;

    t_fstate       r_state;
    t_in           r_item;
    logic [31:0]   r_pos [3];
    logic [IW-1:0] r_ax  [3];
    logic [1:0]    r_axis;
    logic          r_oor;
    logic [63:0]   r_prod;
    logic [31:0]   r_acc;

    logic [SW-1:0] side;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [31:0]   sum;

    always_comb begin
        if (i_cfg.grid_side == '0) begin
            side = SW'(1);
        end else if (32'(i_cfg.grid_side) > 32'(GRID_SIDE_MAX)) begin
            side = SW'(GRID_SIDE_MAX);
        end else begin
            side = SW'(i_cfg.grid_side);
        end
    end

    always_comb begin
        unique case (r_state)
            F_HUS: begin
                mul_a = r_pos[r_axis];
                mul_b = i_cfg.halo_unit_scale;
            end
            F_IDX: begin
                mul_a = r_pos[r_axis];
                mul_b = i_cfg.index_scale;
            end
            F_SQ: begin
                mul_a = 32'(side);
                mul_b = 32'(side);
            end
            F_KSQ: begin
                mul_a = 32'(r_ax[2]);
                mul_b = r_prod[31:0];
            end
            F_JS: begin
                mul_a = 32'(r_ax[1]);
                mul_b = 32'(side);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sum     = r_acc + r_prod[31:0];
    assign o_ready = (r_state == F_IDLE);

    assign o_job_valid        = (r_state == F_SUM);
    assign o_job.func         = r_item.func;
    assign o_job.eigen_first  = r_item.eigen_first;
    assign o_job.eigen_second = r_item.eigen_second;
    assign o_job.eigen_third  = r_item.eigen_third;
    assign o_job.halo_tag     = r_item.halo_tag;
    assign o_job.oor          = r_oor;
    assign o_job.vox          = r_oor ? '0 : sum[CELL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_item   <= i_item;
                        r_pos[0] <= i_item.pos_x;
                        r_pos[1] <= i_item.pos_y;
                        r_pos[2] <= i_item.pos_z;
                        r_axis   <= '0;
                        r_oor    <= 1'b0;
                        r_state  <= (i_item.func == FUNC_QUERY) ? F_HUS : F_IDX;
                    end
                end
                F_HUS: begin
                    r_prod  <= 64'(mul_a) * 64'(mul_b);
                    r_state <= F_SAT;
                end
                F_SAT: begin
                    r_pos[r_axis] <= (r_prod[63:48] != '0) ? '1 : r_prod[47:16];
                    r_state       <= F_IDX;
                end
                F_IDX: begin
                    r_prod  <= 64'(mul_a) * 64'(mul_b);
                    r_state <= F_CMP;
                end
                F_CMP: begin
                    if (r_prod[63:24] >= 40'(side)) begin
                        r_oor <= 1'b1;
                    end
                    r_ax[r_axis] <= r_prod[24 +: IW];
                    if (r_axis == 2'd2) begin
                        r_state <= F_SQ;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= (r_item.func == FUNC_QUERY) ? F_HUS : F_IDX;
                    end
                end
                F_SQ: begin
                    r_prod  <= 64'(mul_a) * 64'(mul_b);
                    r_state <= F_KSQ;
                end
                F_KSQ: begin
                    r_prod  <= 64'(mul_a) * 64'(mul_b);
                    r_state <= F_JS;
                end
                F_JS: begin
                    r_acc   <= r_prod[31:0] + 32'(r_ax[0]);
                    r_prod  <= 64'(mul_a) * 64'(mul_b);
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vwc_back.sv =====
// Back end: clears the type store, then reads, classifies and writes back
// one item at a time and holds the result. Depends on vwc_pkg, vwc_ram.
`timescale 1ns / 1ps
`default_nettype none

module vwc_back #(
    parameter int GRID_SIDE_MAX = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire vwc_pkg::t_cfg i_cfg,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    input  wire vwc_pkg::t_job i_job,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output vwc_pkg::t_out      o_out
);
    import vwc_pkg::*;

    localparam int Depth = GRID_SIDE_MAX * GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int AW    = $clog2(Depth);

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EXEC} t_bstate;

    t_bstate               r_state;
    logic [AW-1:0]         r_clr;
    t_job                  r_job;
    logic                  r_out_valid;
    logic [63:0]           r_tag;
    logic [1:0]            r_type;
    logic [OUT_CELL_W-1:0] r_cell;
    logic                  r_oor;
    logic [31:0]           r_knot;
    logic [31:0]           r_fil;
    logic [31:0]           r_sheet;
    logic [31:0]           r_void;

    logic          we;
    logic [AW-1:0] waddr;
    logic [1:0]    wdata;
    logic [1:0]    rdata;
    logic          k_hit;
    logic          f_hit;
    logic          s_hit;
    logic          v_hit;
    logic          upd;
    logic [1:0]    ty;
    logic [1:0]    web;

    function automatic logic [31:0] bump(input logic [31:0] c, input logic hit);
        bump = (hit && c != '1) ? c + 1'b1 : c;
    endfunction

    assign o_job_ready = (r_state == B_IDLE) && !r_out_valid;
    assign o_clearing  = (r_state == B_CLEAR);

    assign k_hit = i_cfg.eigen_threshold < r_job.eigen_third;
    assign f_hit = (r_job.eigen_second > i_cfg.eigen_threshold)
                && (r_job.eigen_third < i_cfg.eigen_threshold);
    assign s_hit = (r_job.eigen_first > i_cfg.eigen_threshold)
                && (r_job.eigen_second < i_cfg.eigen_threshold);
    assign v_hit = r_job.eigen_first < i_cfg.eigen_threshold;
    assign upd   = !r_job.oor && (r_job.func == FUNC_LOAD);

    // first matching test wins: void, then sheet, filament, knot
    always_comb begin
        priority if (v_hit) begin
            ty = WEB_VOID;
        end else if (s_hit) begin
            ty = WEB_SHEET;
        end else if (f_hit) begin
            ty = WEB_FILAMENT;
        end else if (k_hit) begin
            ty = WEB_KNOT;
        end else begin
            ty = rdata;
        end
    end

    always_comb begin
        if (r_job.oor) begin
            web = WEB_VOID;
        end else if (r_job.func == FUNC_QUERY) begin
            web = rdata;
        end else begin
            web = ty;
        end
    end

    always_comb begin
        if (r_state == B_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = WEB_VOID;
        end else begin
            we    = (r_state == B_EXEC) && upd;
            waddr = r_job.vox[AW-1:0];
            wdata = ty;
        end
    end

    vwc_ram #(
        .WIDTH(2),
        .DEPTH(Depth)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_job_valid && o_job_ready),
        .i_raddr(i_job.vox[AW-1:0]),
        .o_rdata(rdata)
    );

    assign o_out_valid          = r_out_valid;
    assign o_out.halo_tag_out   = r_tag;
    assign o_out.web_type       = r_type;
    assign o_out.cell_index     = r_cell;
    assign o_out.out_of_range   = r_oor;
    assign o_out.knot_total     = r_knot;
    assign o_out.filament_total = r_fil;
    assign o_out.sheet_total    = r_sheet;
    assign o_out.void_total     = r_void;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_knot      <= '0;
            r_fil       <= '0;
            r_sheet     <= '0;
            r_void      <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(Depth - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_job_valid && o_job_ready) begin
                        r_job   <= i_job;
                        r_state <= B_EXEC;
                    end
                end
                B_EXEC: begin
                    r_tag       <= (r_job.func == FUNC_QUERY) ? r_job.halo_tag : '0;
                    r_type      <= web;
                    r_cell      <= r_job.vox[OUT_CELL_W-1:0];
                    r_oor       <= r_job.oor;
                    r_out_valid <= 1'b1;
                    r_knot      <= bump(r_knot, upd && k_hit);
                    r_fil       <= bump(r_fil, upd && f_hit);
                    r_sheet     <= bump(r_sheet, upd && s_hit);
                    r_void      <= bump(r_void, upd && v_hit);
                    r_state     <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/voxel_web_classifier_core.sv =====
// Top level of the voxel web classifier: config registers, front, queue, back.
// Depends on vwc_pkg, vwc_front, vwc_queue, vwc_back.
//
// Loads classify a voxel by its three eigenvalues and update the type store
// and four saturating counters; queries return the stored type of a halo's
// voxel. After reset all GRID_SIDE_MAX^3 entries (262144 at the default) of
// the type store are cleared to void, during which no item is accepted;
// config writes are taken at any time. The front computes the voxel index
// with one shared 32x32 multiplier, stepping through the axes, and takes no
// new item until it has passed its result on; that sets the sustained rate.
// The back reads the store as it accepts an item and writes it back in its
// execute state, and takes no new item until its result is taken; a short
// queue lets the front work on the next item while the back or the output stalls.
`timescale 1ns / 1ps
`default_nettype none

module voxel_web_classifier_core #(
    parameter int GRID_SIDE_MAX = vwc_pkg::GRID_SIDE_MAX_DEF,
    parameter int QUEUE_DEPTH   = vwc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire vwc_pkg::t_in                  i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output vwc_pkg::t_out                      o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [vwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);
    import vwc_pkg::*;

    t_cfg r_cfg;
    logic clearing;
    logic front_ready;
    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_side       <= GRID_SIDE_RST;
            r_cfg.index_scale     <= SCALE_RST;
            r_cfg.halo_unit_scale <= SCALE_RST;
            r_cfg.eigen_threshold <= THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_SIDE:   r_cfg.grid_side       <= i_cfg_data[6:0];
                CFG_INDEX_SCALE: r_cfg.index_scale     <= i_cfg_data;
                CFG_HALO_SCALE:  r_cfg.halo_unit_scale <= i_cfg_data;
                CFG_THRESHOLD:   r_cfg.eigen_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = front_ready && !clearing;

    vwc_front #(
        .GRID_SIDE_MAX(GRID_SIDE_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_in_valid && !clearing),
        .o_ready    (front_ready),
        .i_item     (i_in_item),
        .o_job_valid(push_valid),
        .i_job_ready(push_ready),
        .o_job      (push_job)
    );

    vwc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(push_valid),
        .o_push_ready(push_ready),
        .i_push_job  (push_job),
        .o_pop_valid (pop_valid),
        .i_pop_ready (pop_ready),
        .o_pop_job   (pop_job)
    );

    vwc_back #(
        .GRID_SIDE_MAX(GRID_SIDE_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job_valid(pop_valid),
        .o_job_ready(pop_ready),
        .i_job      (pop_job),
        .o_clearing (clearing),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out_item)
    );

    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !(i_in_valid && o_in_ready)
    ) else $error("item accepted during store clear");

    a_no_result_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_out_valid && !pop_ready
    ) else $error("back active during store clear");

    a_oor_result_void: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_of_range |->
            o_out_item.web_type == WEB_VOID && o_out_item.cell_index == '0
    ) else $error("out of range result carries a cell or a type");

    a_counts_monotonic: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            o_out_item.knot_total >= $past(o_out_item.knot_total)
            && o_out_item.void_total >= $past(o_out_item.void_total)
    ) else $error("classification counter went backwards");

endmodule

`default_nettype wire

// ===== bench/voxel_web_classifier_core_checker.sv =====
// Result checker for voxel_web_classifier_core: watches the config, input and
// output channels, predicts each result and compares it field by field.
// Depends on vwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwc_checker #(
    parameter int GRID_SIDE_MAX = vwc_pkg::GRID_SIDE_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire vwc_pkg::t_in                  i_in_item,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire vwc_pkg::t_out                 i_out_item,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [vwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    import vwc_pkg::*;

    localparam int STORE_DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX * GRID_SIDE_MAX;

    bit [1:0]           web_store [STORE_DEPTH];
    logic [6:0]         grid_side;
    logic [31:0]        index_scale;
    logic [31:0]        halo_scale;
    logic signed [31:0] threshold;
    logic [31:0]        knot_cnt;
    logic [31:0]        filament_cnt;
    logic [31:0]        sheet_cnt;
    logic [31:0]        void_cnt;
    t_out               web_results_q [$];
    int                 mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic t_out classify_item(t_in it);
        t_out        r;
        logic [31:0] p [3];
        logic [63:0] prod;
        logic [39:0] ax [3];
        int unsigned side;
        logic        oor;
        logic [31:0] vox_idx;
        logic [1:0]  wt;
        side = (grid_side == 7'd0) ? 1 :
               (grid_side > GRID_SIDE_MAX) ? GRID_SIDE_MAX : int'(grid_side);
        p[0] = it.pos_x;
        p[1] = it.pos_y;
        p[2] = it.pos_z;
        oor = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (it.func == FUNC_QUERY) begin
                prod = (64'(p[a]) * 64'(halo_scale)) >> 16;
                p[a] = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
            end
            prod  = 64'(p[a]) * 64'(index_scale);
            ax[a] = prod[63:24];
            if (ax[a] >= 40'(side))
                oor = 1'b1;
        end
        vox_idx = 32'd0;
        if (!oor)
            vox_idx = ax[0][31:0] + ax[1][31:0] * side + ax[2][31:0] * side * side;
        wt = WEB_VOID;
        if (it.func == FUNC_QUERY) begin
            if (!oor)
                wt = web_store[vox_idx];
        end else if (!oor) begin
            wt = web_store[vox_idx];
            if ($signed(it.eigen_third) > threshold) begin
                knot_cnt = sat_inc(knot_cnt);
                wt = WEB_KNOT;
            end
            if ($signed(it.eigen_second) > threshold && $signed(it.eigen_third) < threshold) begin
                filament_cnt = sat_inc(filament_cnt);
                wt = WEB_FILAMENT;
            end
            if ($signed(it.eigen_first) > threshold && $signed(it.eigen_second) < threshold) begin
                sheet_cnt = sat_inc(sheet_cnt);
                wt = WEB_SHEET;
            end
            if ($signed(it.eigen_first) < threshold) begin
                void_cnt = sat_inc(void_cnt);
                wt = WEB_VOID;
            end
            web_store[vox_idx] = wt;
        end
        r.halo_tag_out   = (it.func == FUNC_QUERY) ? it.halo_tag : 64'd0;
        r.web_type       = wt;
        r.cell_index     = vox_idx[OUT_CELL_W-1:0];
        r.out_of_range   = oor;
        r.knot_total     = knot_cnt;
        r.filament_total = filament_cnt;
        r.sheet_total    = sheet_cnt;
        r.void_total     = void_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            grid_side    = GRID_SIDE_RST;
            index_scale  = SCALE_RST;
            halo_scale   = SCALE_RST;
            threshold    = THRESHOLD_RST;
            knot_cnt     = '0;
            filament_cnt = '0;
            sheet_cnt    = '0;
            void_cnt     = '0;
            foreach (web_store[n])
                web_store[n] = WEB_VOID;
            web_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_SIDE:   grid_side   = i_cfg_data[6:0];
                    CFG_INDEX_SCALE: index_scale = i_cfg_data;
                    CFG_HALO_SCALE:  halo_scale  = i_cfg_data;
                    CFG_THRESHOLD:   threshold   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (web_results_q.size() == 0) begin
                    $error("result item with no expectation waiting");
                    mismatches++;
                end else begin
                    exp_r = web_results_q.pop_front();
                    check_field("halo_tag_out", exp_r.halo_tag_out, i_out_item.halo_tag_out);
                    check_field("web_type", exp_r.web_type, i_out_item.web_type);
                    check_field("cell_index", exp_r.cell_index, i_out_item.cell_index);
                    check_field("out_of_range", exp_r.out_of_range, i_out_item.out_of_range);
                    check_field("knot_total", exp_r.knot_total, i_out_item.knot_total);
                    check_field("filament_total", exp_r.filament_total,
                                i_out_item.filament_total);
                    check_field("sheet_total", exp_r.sheet_total, i_out_item.sheet_total);
                    check_field("void_total", exp_r.void_total, i_out_item.void_total);
                end
            end
            if (i_in_valid && i_in_ready)
                web_results_q.push_back(classify_item(i_in_item));
        end
        o_fail_count <= mismatches;
        o_pending    <= web_results_q.size();
    end

endmodule

`default_nettype wire

// ===== bench/voxel_web_classifier_core_tb.sv =====
// Testbench top for voxel_web_classifier_core: clock, reset, config writes,
// directed and random load/query items with idling, and the verdict.
// Depends on vwc_pkg, voxel_web_classifier_core and vwc_checker.
`timescale 1ns / 1ps
`default_nettype none

module voxel_web_classifier_core_tb;

    import vwc_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    bit                   hold_req = 1'b0;
    bit                   hold_seen = 1'b0;
    int                   hold_left = 0;

    int unsigned          cur_side = 64;
    logic [31:0]          cur_iscale = SCALE_RST;
    logic [31:0]          cur_hscale = SCALE_RST;
    logic signed [31:0]   cur_thr = THRESHOLD_RST;

    voxel_web_classifier_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    vwc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] grid_pos(int unsigned a);
        return (32'(a) << 8) | 32'h80;
    endfunction

    function automatic t_in mk_item(logic func, logic [31:0] px, logic [31:0] py,
                                    logic [31:0] pz, logic signed [31:0] e1,
                                    logic signed [31:0] e2, logic signed [31:0] e3,
                                    logic [63:0] tag);
        t_in it;
        it.func         = func;
        it.pos_x        = px;
        it.pos_y        = py;
        it.pos_z        = pz;
        it.eigen_first  = e1;
        it.eigen_second = e2;
        it.eigen_third  = e3;
        it.halo_tag     = tag;
        return it;
    endfunction

    // position whose axis index lands on (or just below) the wanted cell
    function automatic logic [31:0] load_pos(int unsigned a);
        logic [63:0] num;
        if (cur_iscale == 32'd0)
            return $urandom;
        num = (64'(a) << 24) + 64'($urandom_range(0, 24'hFF_FFFF));
        num = num / 64'(cur_iscale);
        return (num > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : num[31:0];
    endfunction

    function automatic logic [31:0] query_pos(int unsigned a);
        logic [63:0] num;
        if (cur_hscale == 32'd0)
            return $urandom;
        num = (64'(load_pos(a)) << 16) + 64'($urandom_range(0, 16'hFFFF));
        num = num / 64'(cur_hscale);
        return (num > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : num[31:0];
    endfunction

    function automatic logic [31:0] near_thr_eigen();
        if ($urandom_range(99) < 60)
            return cur_thr + 32'($urandom_range(0, 6)) - 32'd3;
        return $urandom;
    endfunction

    function automatic t_in random_item();
        t_in         it;
        int unsigned ax;
        logic [31:0] p [3];
        it          = '0;
        it.func     = ($urandom_range(99) < 40) ? FUNC_QUERY : FUNC_LOAD;
        it.halo_tag = {$urandom, $urandom};
        if ($urandom_range(99) < 10) begin
            it.pos_x        = $urandom;
            it.pos_y        = $urandom;
            it.pos_z        = $urandom;
            it.eigen_first  = $urandom;
            it.eigen_second = $urandom;
            it.eigen_third  = $urandom;
            return it;
        end
        for (int a = 0; a < 3; a++) begin
            ax   = ($urandom_range(99) < 5) ? cur_side : $urandom_range(0, cur_side - 1);
            p[a] = (it.func == FUNC_QUERY) ? query_pos(ax) : load_pos(ax);
        end
        it.pos_x        = p[0];
        it.pos_y        = p[1];
        it.pos_z        = p[2];
        it.eigen_first  = near_thr_eigen();
        it.eigen_second = near_thr_eigen();
        it.eigen_third  = near_thr_eigen();
        return it;
    endfunction

    task automatic send_item(input t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic run_phase(input logic [31:0] side_data, input logic [31:0] iscale,
                             input logic [31:0] hscale, input logic [31:0] thr,
                             input int n, input int unsigned send_pct,
                             input int unsigned recv_pct);
        cfg_write(CFG_GRID_SIDE, side_data);
        cfg_write(CFG_INDEX_SCALE, iscale);
        cfg_write(CFG_HALO_SCALE, hscale);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
        cur_side   = (side_data[6:0] == 7'd0) ? 1 :
                     (side_data[6:0] > GRID_SIDE_MAX_DEF) ? GRID_SIDE_MAX_DEF :
                     int'(side_data[6:0]);
        cur_iscale = iscale;
        cur_hscale = hscale;
        cur_thr    = thr;
        send_idle_pct   = send_pct;
        recv_stall_pct <= recv_pct;
        repeat (n) send_item(random_item());
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // items for each classification outcome, grid corners, out-of-range cells
        send_item(mk_item(FUNC_LOAD, grid_pos(0), grid_pos(0), grid_pos(0),
                          32'sd1, 32'sd1, 32'sd1, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(1), grid_pos(0), grid_pos(0),
                          32'sd1, 32'sd1, -32'sd1, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(2), grid_pos(0), grid_pos(0),
                          32'sd1, -32'sd1, -32'sd1, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(3), grid_pos(0), grid_pos(0),
                          -32'sd1, -32'sd1, -32'sd1, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(4), grid_pos(0), grid_pos(0),
                          32'sd0, 32'sd0, 32'sd0, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(0), grid_pos(0), grid_pos(0),
                          32'sd0, 32'sd0, 32'sd0, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(5), grid_pos(0), grid_pos(0),
                          -32'sd1, 32'sd1, 32'sd1, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(6), grid_pos(0), grid_pos(0),
                          32'sd1, -32'sd1, 32'sd1, 64'd0));
        send_item(mk_item(FUNC_LOAD, 32'h3FFF, 32'h3FFF, 32'h3FFF,
                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(63), grid_pos(62), grid_pos(63),
                          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 64'd0));
        send_item(mk_item(FUNC_LOAD, grid_pos(64), grid_pos(0), grid_pos(0),
                          32'sd1, 32'sd1, 32'sd1, 64'd0));
        send_item(mk_item(FUNC_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          -32'sd1, 32'sd1, 32'sd1, '1));
        send_item(mk_item(FUNC_QUERY, grid_pos(0), grid_pos(0), grid_pos(0),
                          32'sd0, 32'sd0, 32'sd0, 64'd0));
        send_item(mk_item(FUNC_QUERY, grid_pos(1), grid_pos(0), grid_pos(0),
                          32'sd0, 32'sd0, 32'sd0, '1));
        send_item(mk_item(FUNC_QUERY, grid_pos(2), grid_pos(0), grid_pos(0),
                          '1, '1, '1, 64'h0123_4567_89AB_CDEF));
        send_item(mk_item(FUNC_QUERY, grid_pos(5), grid_pos(0), grid_pos(0),
                          32'sd0, 32'sd0, 32'sd0, 64'hFEDC_BA98_7654_3210));
        send_item(mk_item(FUNC_QUERY, grid_pos(6), grid_pos(0), grid_pos(0),
                          32'sd0, 32'sd0, 32'sd0, 64'd6));
        send_item(mk_item(FUNC_QUERY, 32'h3F00, 32'h3FFF, 32'h3F80,
                          32'sd0, 32'sd0, 32'sd0, 64'd7));
        send_item(mk_item(FUNC_QUERY, grid_pos(63), grid_pos(62), grid_pos(63),
                          32'sd0, 32'sd0, 32'sd0, 64'd8));
        send_item(mk_item(FUNC_QUERY, grid_pos(10), grid_pos(10), grid_pos(10),
                          32'sd0, 32'sd0, 32'sd0, 64'd9));
        send_item(mk_item(FUNC_QUERY, grid_pos(0), grid_pos(0), grid_pos(64),
                          32'sd0, 32'sd0, 32'sd0, 64'd10));
        send_item(mk_item(FUNC_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'sd0, 32'sd0, 32'sd0, '1));
        drain();

        // back-pressure: output held off while items keep coming
        hold_req <= ~hold_req;
        repeat (40) send_item(random_item());
        drain();

        run_phase(32'd4, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 150, 0, 0);
        run_phase(32'd4, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000, 120, 87, 0);
        run_phase(32'd64, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 120, 0, 87);
        run_phase(32'd0, 32'h0000_8000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 60, 38, 38);
        run_phase(32'd127, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 60, 0, 0);
        run_phase(32'hFFFF_FF83, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 40, 87, 0);
        run_phase(32'd8, 32'h0001_0000, 32'h0001_0000, 32'h0000_0005, 150, 38, 38);
        run_phase(32'd2, 32'h0003_0000, 32'h0000_4000, 32'h0000_0000, 150, 0, 87);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
